@@ rtl/lrufr_pkg.sv @@
// Shared types and constants for the LRU frame replacer.
// Used by lrufr_chain and lru_frame_replacer; no dependencies.
package lrufr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int POS_W      = $clog2(NUM_FRAMES);
    localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
    localparam int CMD_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_VICTIM = 2'd0,
        CMD_PIN    = 2'd1,
        CMD_UNPIN  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FRAME_W-1:0] frame_no;
    } item_t;

    typedef struct packed {
        logic               victim_valid;
        logic [FRAME_W-1:0] victim_frame;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

@@ rtl/lrufr_chain.sv @@
// Shifting cell chain that holds evictable frames, oldest in cell 0.
// Removes a frame and appends one in the same cycle. Depends on lrufr_pkg.
module lrufr_chain (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  lrufr_pkg::item_t  item,
    output lrufr_pkg::result_t result,
    output logic [lrufr_pkg::COUNT_W-1:0] count
);

    logic [lrufr_pkg::FRAME_W-1:0] cell_reg  [lrufr_pkg::NUM_FRAMES];
    logic [lrufr_pkg::FRAME_W-1:0] cell_next [lrufr_pkg::NUM_FRAMES];
    logic [lrufr_pkg::COUNT_W-1:0] held_count_reg;
    logic [lrufr_pkg::COUNT_W-1:0] held_count_next;

    logic [lrufr_pkg::NUM_FRAMES-1:0] match;
    logic [lrufr_pkg::POS_W-1:0]      hit_pos;
    logic [lrufr_pkg::POS_W-1:0]      drop_pos;
    logic [lrufr_pkg::COUNT_W-1:0]    cnt_mid;
    logic                             hit;
    logic                             is_victim;
    logic                             is_pin;
    logic                             is_unpin;
    logic                             in_range;
    logic                             not_empty;
    logic                             drop;
    logic                             append;

    always_comb begin
        is_victim = (item.cmd == lrufr_pkg::CMD_VICTIM);
        is_pin    = (item.cmd == lrufr_pkg::CMD_PIN);
        is_unpin  = (item.cmd == lrufr_pkg::CMD_UNPIN);
        in_range  = ({1'b0, item.frame_no} < lrufr_pkg::COUNT_W'(lrufr_pkg::NUM_FRAMES));
        not_empty = (held_count_reg != '0);

        // match is at most one-hot: a frame is held once
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) begin
            match[i] = (lrufr_pkg::COUNT_W'(i) < held_count_reg)
                       && (cell_reg[i] == item.frame_no);
        end
        hit = |match;

        hit_pos = '0;
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) begin
            if (match[i]) begin
                hit_pos = hit_pos | lrufr_pkg::POS_W'(i);
            end
        end

        drop     = (is_victim && not_empty) || ((is_pin || is_unpin) && in_range && hit);
        drop_pos = is_victim ? '0 : hit_pos;
        cnt_mid  = held_count_reg - lrufr_pkg::COUNT_W'(drop);
        append   = is_unpin && in_range
                   && (cnt_mid < lrufr_pkg::COUNT_W'(lrufr_pkg::NUM_FRAMES));
        held_count_next = cnt_mid + lrufr_pkg::COUNT_W'(append);

        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) begin
            cell_next[i] = cell_reg[i];
            if (i < lrufr_pkg::NUM_FRAMES - 1) begin
                if (drop && (lrufr_pkg::POS_W'(i) >= drop_pos)) begin
                    cell_next[i] = cell_reg[i + 1];
                end
            end
            if (append && (lrufr_pkg::COUNT_W'(i) == cnt_mid)) begin
                cell_next[i] = item.frame_no;
            end
        end

        result.victim_valid = is_victim && not_empty;
        result.victim_frame = (is_victim && not_empty) ? cell_reg[0] : '0;
        result.count        = held_count_next;
    end

    assign count = held_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
        end else if (en) begin
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

endmodule

@@ rtl/lru_frame_replacer.sv @@
// LRU frame replacer top level: input register, cell chain, result register.
// Depends on lrufr_pkg and lrufr_chain.
//
// Takes one command per cycle while the result side does not stall and returns
// one result per command, through the input register and then the result
// register. The command sits in an input register; once the result register
// can be refilled, the cell chain removes the oldest frame on a victim or any
// matching frame, appends an unpinned frame at the young end and shifts the
// younger cells down, and the outcome goes to the result register. The input
// side stays ready while the result register can be refilled, so a new command
// is taken every cycle under full flow. Commands: 0 victim, 1 pin, 2 unpin;
// code 3 changes nothing. Frame state is empty after reset, with no clearing pass.
module lru_frame_replacer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] frame number, [7:6] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] victim_frame, [12:6] count, [15:13] zero
    output logic        m_tuser    // [0] victim_valid
);

    lrufr_pkg::item_t   item_reg;
    logic               item_valid_reg;
    lrufr_pkg::result_t res_reg;
    lrufr_pkg::result_t res_next;
    logic               res_valid_reg;
    logic [lrufr_pkg::COUNT_W-1:0] held_count;
    logic               fire;
    logic               s_xfer;

    assign fire     = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || fire;
    assign s_xfer   = s_tvalid && s_tready;

    lrufr_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (fire),
        .item    (item_reg),
        .result  (res_next),
        .count   (held_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg.cmd      <= s_tuser;
            item_reg.frame_no <= s_tdata[lrufr_pkg::FRAME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.victim_valid;
    assign m_tdata  = {3'b000, res_reg.count, res_reg.victim_frame};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count <= lrufr_pkg::COUNT_W'(lrufr_pkg::NUM_FRAMES))
        else $error("held count above frame total");

    a_victim_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_next.victim_valid) |=> (held_count == $past(held_count) - 1'b1))
        else $error("victim did not shrink the set by one");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[lrufr_pkg::FRAME_W-1:0] == '0))
        else $error("victim frame nonzero without victim");

    a_count_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (res_reg.count == held_count))
        else $error("result count differs from chain count");
`endif

endmodule

@@ dv/tb_lru_frame_replacer.sv @@
// Testbench for lru_frame_replacer: directed table, then random pin/unpin/victim traffic.
// Expected results come from an in-bench LRU list model; needs rtl/lrufr_pkg.sv
// and the RTL of lru_frame_replacer.
`timescale 1ns / 100ps

module tb_lru_frame_replacer;

    localparam logic [lrufr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [lrufr_pkg::CMD_W-1:0]   op;
        logic [lrufr_pkg::FRAME_W-1:0] fid;
        logic                          known;
        lrufr_pkg::result_t            res;
    } dir_row_t;

    localparam int N_DIR = 17;
    localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
        '{lrufr_pkg::CMD_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
        '{CMD_UNUSED,            6'd63, 1'b1, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_PIN,    6'd5,  1'b1, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd1}},
        '{lrufr_pkg::CMD_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0, 7'd2}},
        '{lrufr_pkg::CMD_UNPIN,  6'd0,  1'b0, '{1'b0, 6'd0, 7'd0}},
        '{CMD_UNUSED,            6'd0,  1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_VICTIM, 6'd0,  1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_VICTIM, 6'd63, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_UNPIN,  6'd42, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_UNPIN,  6'd21, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_PIN,    6'd42, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_PIN,    6'd42, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_UNPIN,  6'd21, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_VICTIM, 6'd21, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{lrufr_pkg::CMD_PIN,    6'd21, 1'b0, '{1'b0, 6'd0, 7'd0}}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [5:0] frame number, [7:6] zero
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [5:0] victim_frame, [12:6] count, [15:13] zero
    logic        m_tuser;   // [0] victim_valid

    lru_frame_replacer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // LRU list model: slot 0 is the oldest unpinned frame
    logic [lrufr_pkg::FRAME_W-1:0] lru_list[$];
    bit                            frame_held [lrufr_pkg::NUM_FRAMES];
    lrufr_pkg::result_t            pending_results[$];

    int  n_mismatch;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  hold_rx;

    function automatic void unlink_frame(logic [lrufr_pkg::FRAME_W-1:0] fid);
        for (int i = 0; i < lru_list.size(); i++) begin
            if (lru_list[i] == fid) begin
                lru_list.delete(i);
                break;
            end
        end
    endfunction

    function automatic lrufr_pkg::result_t lru_predict(logic [lrufr_pkg::CMD_W-1:0] op,
                                                      logic [lrufr_pkg::FRAME_W-1:0] fid);
        lrufr_pkg::result_t r;
        r = '0;
        case (op)
            lrufr_pkg::CMD_VICTIM: begin
                if (lru_list.size() > 0) begin
                    r.victim_valid = 1'b1;
                    r.victim_frame = lru_list.pop_front();
                    frame_held[r.victim_frame] = 1'b0;
                end
            end
            lrufr_pkg::CMD_PIN: begin
                if (frame_held[fid]) begin
                    unlink_frame(fid);
                    frame_held[fid] = 1'b0;
                end
            end
            lrufr_pkg::CMD_UNPIN: begin
                if (frame_held[fid])
                    unlink_frame(fid);
                if (lru_list.size() < lrufr_pkg::NUM_FRAMES) begin
                    lru_list = {lru_list, fid};
                    frame_held[fid] = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = lrufr_pkg::COUNT_W'(lru_list.size());
        return r;
    endfunction

    task automatic send_cmd(input logic [lrufr_pkg::CMD_W-1:0] op,
                            input logic [lrufr_pkg::FRAME_W-1:0] fid,
                            input bit known = 1'b0,
                            input lrufr_pkg::result_t typed = '0);
        lrufr_pkg::result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, fid};
        do @(posedge aclk); while (!s_tready);
        r = lru_predict(op, fid);
        pending_results = {pending_results, (known ? typed : r)};
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    function automatic logic [lrufr_pkg::FRAME_W-1:0] pick_frame();
        if (lru_list.size() > 0 && $urandom_range(0, 1) == 1)
            return lru_list[$urandom_range(0, lru_list.size() - 1)];
        return lrufr_pkg::FRAME_W'($urandom_range(0, lrufr_pkg::NUM_FRAMES - 1));
    endfunction

    task automatic random_mix(input int n_items, input int unpin_pct);
        int sel;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < unpin_pct)
                send_cmd(lrufr_pkg::CMD_UNPIN, pick_frame());
            else if (sel < unpin_pct + (95 - unpin_pct) / 2)
                send_cmd(lrufr_pkg::CMD_PIN, pick_frame());
            else if (sel < 95)
                send_cmd(lrufr_pkg::CMD_VICTIM,
                         lrufr_pkg::FRAME_W'($urandom_range(0, lrufr_pkg::NUM_FRAMES - 1)));
            else
                send_cmd(CMD_UNUSED,
                         lrufr_pkg::FRAME_W'($urandom_range(0, lrufr_pkg::NUM_FRAMES - 1)));
        end
    endtask

    task automatic fill_all();
        logic [lrufr_pkg::FRAME_W-1:0] order [lrufr_pkg::NUM_FRAMES];
        logic [lrufr_pkg::FRAME_W-1:0] tmp;
        int j;
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++)
            order[i] = lrufr_pkg::FRAME_W'(i);
        for (int i = lrufr_pkg::NUM_FRAMES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++)
            send_cmd(lrufr_pkg::CMD_UNPIN, order[i]);
    endtask

    task automatic note_mismatch(input string what, input lrufr_pkg::result_t want);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("%0t: %s exp valid=%0d frame=%0d count=%0d, %s%0d frame=%0d count=%0d",
                     $realtime, what, want.victim_valid, want.victim_frame, want.count,
                     "got valid=", m_tuser, m_tdata[5:0], m_tdata[12:6]);
    endtask

    always @(posedge aclk) begin : result_check
        lrufr_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected transfer:", '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.victim_valid || m_tdata[5:0] !== want.victim_frame ||
                    m_tdata[12:6] !== want.count)
                    note_mismatch("result mismatch:", want);
            end
        end
    end

    initial begin : rx_side
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        n_mismatch = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_rx    = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++)
            send_cmd(DIR_ROWS[i].op, DIR_ROWS[i].fid, DIR_ROWS[i].known, DIR_ROWS[i].res);

        // fill to capacity, then churn with the set full or nearly full
        fill_all();
        for (int i = 0; i < 8; i++)
            send_cmd(lrufr_pkg::CMD_UNPIN, pick_frame());
        random_mix(150, 65);

        // long receiver stall with the sender pushing back-to-back
        tx_idle_on = 1'b0;
        hold_rx = 1'b1;
        random_mix(24, 45);
        tx_idle_on = 1'b1;

        // sender waits for the pipeline to drain
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        random_mix(250, 45);

        // final stretch without idling, drained by victims
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_mix(60, 55);
        while (lru_list.size() > 0)
            send_cmd(lrufr_pkg::CMD_VICTIM, pick_frame());
        send_cmd(lrufr_pkg::CMD_VICTIM, 6'd63);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        n_mismatch += pending_results.size();

        if (n_mismatch == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
